[hw/rtl/tsw_pkg.sv]
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants for the tick scheduler
// Item and result layouts, operation codes, and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 3;
  localparam int FIELD_W  = 16;
  localparam int MASK_W   = 8;

  // Operation codes carried in the func field
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd2;

  localparam logic [BYTE_W-1:0] RUNS_MAX = 8'hFF;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               slave_watchdog;
    logic [BYTE_W-1:0]  ack_byte;
    logic [IDX_W-1:0]   slot_index;
    logic               slot_present;
    logic [FIELD_W-1:0] slot_delay;
    logic [FIELD_W-1:0] slot_period;
  } item_t;

  typedef struct packed {
    logic              lost_slave;
    logic [BYTE_W-1:0] tick_byte;
    logic [BYTE_W-1:0] ack_captured;
    logic [MASK_W-1:0] due_mask;
    logic [BYTE_W-1:0] run_count;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic tick_fail;
    logic tick_ok;
    logic write_slot;
    logic disp_read;
    logic walk_step;
    logic disp_finish;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              halted;
    logic              wd_fail;
    logic              idx_ok;
    logic              walk_last;
  } ctrl_stat_t;

endpackage

[hw/rtl/tsw_item_if.sv]
// ----------------------------------------------------------------------------
// tsw_item_if: input item channel
// Valid/ready handshake carrying one scheduler item.
// ----------------------------------------------------------------------------
interface tsw_item_if;
  logic            valid;
  logic            ready;
  tsw_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/tsw_result_if.sv]
// ----------------------------------------------------------------------------
// tsw_result_if: result item channel
// Valid/ready handshake carrying one scheduler result.
// ----------------------------------------------------------------------------
interface tsw_result_if;
  logic              valid;
  logic              ready;
  tsw_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/tsw_dp.sv]
// ----------------------------------------------------------------------------
// tsw_dp: scheduler datapath
// Holds the slot memory, valid bits, watchdog state, tick message register,
// walk counter and the result registers. Acts on controller commands.
// ----------------------------------------------------------------------------
module tsw_dp #(
  parameter int NUM_SLOTS   = tsw_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = tsw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tsw_pkg::item_t              in_data,
  input  logic                        cfg_wr_en,
  input  logic [tsw_pkg::BYTE_W-1:0]  cfg_wr_data,
  input  tsw_pkg::ctrl_cmd_t          cmd,
  output tsw_pkg::ctrl_stat_t         stat,
  output tsw_pkg::result_t            out_data
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]     cd;
    logic [COUNT_WIDTH-1:0]     reload;
    logic [tsw_pkg::BYTE_W-1:0] runs;
  } slot_t;

  slot_t                        mem [NUM_SLOTS];
  slot_t                        rd_data;
  slot_t                        wr_data;
  slot_t                        walk_entry;
  logic [SLOT_W-1:0]            rd_addr;
  logic [SLOT_W-1:0]            wr_addr;
  logic                         wr_en;

  tsw_pkg::item_t               item_q;
  logic [tsw_pkg::BYTE_W-1:0]   tick_message;
  logic                         halted;
  logic                         first_tick;
  logic                         wd_prev;
  logic [NUM_SLOTS-1:0]         valid;
  logic [SLOT_W-1:0]            cnt;

  logic [tsw_pkg::BYTE_W-1:0]   res_tick;
  logic [tsw_pkg::BYTE_W-1:0]   res_ack;
  logic [tsw_pkg::MASK_W-1:0]   res_due;
  logic [tsw_pkg::BYTE_W-1:0]   res_runs;

  logic [SLOT_W-1:0]            idx;
  logic                         walk_hit;
  logic                         due_now;
  logic [tsw_pkg::MASK_W-1:0]   due_bit;
  logic [tsw_pkg::BYTE_W-1:0]   disp_runs;

  assign idx       = SLOT_W'(item_q.slot_index);
  assign walk_hit  = valid[cnt];
  assign due_now   = (rd_data.cd == '0);
  assign disp_runs = valid[idx] ? rd_data.runs : '0;

  assign stat.func      = item_q.func;
  assign stat.halted    = halted;
  assign stat.wd_fail   = !first_tick && (wd_prev == item_q.slave_watchdog);
  assign stat.idx_ok    = (int'(item_q.slot_index) < NUM_SLOTS);
  assign stat.walk_last = (cnt == LAST_SLOT);

  // Bit of the due mask for the slot under walk; slots past 7 have none
  always_comb begin
    for (int i = 0; i < tsw_pkg::MASK_W; i++) begin
      due_bit[i] = (int'(cnt) == i);
    end
  end

  // Next contents of the slot under walk
  always_comb begin
    walk_entry = rd_data;
    if (due_now) begin
      if (rd_data.runs != tsw_pkg::RUNS_MAX) begin
        walk_entry.runs = rd_data.runs + 8'd1;
      end
      if (rd_data.reload != '0) begin
        walk_entry.cd = rd_data.reload;
      end
    end else begin
      walk_entry.cd = rd_data.cd - COUNT_WIDTH'(1);
    end
  end

  // Slot memory port selection
  always_comb begin
    rd_addr = '0;
    if (cmd.disp_read) begin
      rd_addr = idx;
    end else if (cmd.walk_step) begin
      rd_addr = cnt + SLOT_W'(1);
    end

    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (cmd.write_slot) begin
      wr_en          = 1'b1;
      wr_data.cd     = item_q.slot_present ? COUNT_WIDTH'(item_q.slot_delay) : '0;
      wr_data.reload = item_q.slot_present ? COUNT_WIDTH'(item_q.slot_period) : '0;
      wr_data.runs   = '0;
    end else if (cmd.walk_step) begin
      wr_en   = walk_hit;
      wr_addr = cnt;
      wr_data = walk_entry;
    end else if (cmd.disp_finish) begin
      wr_en        = (disp_runs != '0);
      wr_data.runs = rd_data.runs - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_message <= '0;
      halted       <= 1'b0;
      first_tick   <= 1'b1;
      wd_prev      <= 1'b0;
      valid        <= '0;
      cnt          <= '0;
    end else begin
      if (cfg_wr_en) begin
        tick_message <= cfg_wr_data;
      end
      if (cmd.tick_fail) begin
        halted <= 1'b1;
      end
      if (cmd.tick_ok) begin
        first_tick <= 1'b0;
        wd_prev    <= item_q.slave_watchdog;
        cnt        <= '0;
      end
      if (cmd.walk_step) begin
        cnt <= cnt + SLOT_W'(1);
      end
      if (cmd.write_slot) begin
        valid[idx] <= item_q.slot_present;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item_q   <= in_data;
      res_tick <= '0;
      res_ack  <= '0;
      res_due  <= '0;
      res_runs <= '0;
    end
    if (cmd.tick_ok) begin
      res_tick <= tick_message;
      res_ack  <= item_q.ack_byte;
    end
    if (cmd.walk_step && walk_hit && due_now) begin
      res_due <= res_due | due_bit;
    end
    if (cmd.disp_finish) begin
      res_runs <= disp_runs;
    end
    if (cmd.load_out) begin
      out_data.lost_slave   <= halted;
      out_data.tick_byte    <= res_tick;
      out_data.ack_captured <= res_ack;
      out_data.due_mask     <= res_due;
      out_data.run_count    <= res_runs;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag dropped without reset");

  a_fail_halts: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_fail |=> halted && !first_tick)
    else $error("failed watchdog check did not halt");

  a_walk_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step && !stat.walk_last |=> cnt == $past(cnt) + SLOT_W'(1))
    else $error("walk counter did not advance");
`endif

endmodule

[hw/rtl/tsw_ctrl.sv]
// ----------------------------------------------------------------------------
// tsw_ctrl: scheduler controller
// One-hot sequencer: accept an item, decode it, walk slots, write one slot or
// read-modify-write one slot, then move the result into the output register.
// ----------------------------------------------------------------------------
module tsw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tsw_pkg::ctrl_stat_t  stat,
  output tsw_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WALK = 5'b00100,
    S_DISP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (!stat.halted) begin
          case (stat.func)
            tsw_pkg::FUNC_TICK: begin
              if (stat.wd_fail) begin
                cmd.tick_fail = 1'b1;
              end else begin
                cmd.tick_ok = 1'b1;
                state_next  = S_WALK;
              end
            end
            tsw_pkg::FUNC_WRITE: begin
              cmd.write_slot = stat.idx_ok;
            end
            tsw_pkg::FUNC_DISPATCH: begin
              if (stat.idx_ok) begin
                cmd.disp_read = 1'b1;
                state_next    = S_DISP;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DONE;
        end
      end
      S_DISP: begin
        cmd.disp_finish = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted item not decoded next cycle");

  a_walk_runs: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && !stat.walk_last |=> state == S_WALK)
    else $error("slot walk ended early");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !out_valid |=> out_valid && state == S_IDLE)
    else $error("result not moved into free output register");
`endif

endmodule

[hw/rtl/tick_scheduler_with_slave_watchdog_top.sv]
// ----------------------------------------------------------------------------
// tick_scheduler_with_slave_watchdog_top: master tick engine with slave check
// Time-triggered scheduler tick engine: task slot load, dispatch and tick
// with a slave watchdog toggle check. Controller plus datapath.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. A tick checks that the
// slave watchdog level toggled since the last tick (the first tick after reset
// only records it); a failed check halts the block for good, and every later
// item returns lost_slave = 1 with all other fields zero. A good tick returns
// the tick message and the acknowledge byte, then walks every slot, one per
// cycle through the slot memory's read and write ports, and reports the
// slots that became due in due_mask (slots 0 to 7 only). On the way to the
// output register, write, unused-code, halted and failed-tick items pass
// through decode only; a dispatch in range adds a slot update step and a good
// tick adds the slot walk. The next item is taken in the cycle after the
// result is loaded, even while that result still waits on out_ch. Slots come
// out of reset empty at once through per-slot valid bits; no clearing pass.
// Write tick_message through cfg_wr_en / cfg_wr_data only while the block is
// idle.
// ----------------------------------------------------------------------------
module tick_scheduler_with_slave_watchdog_top #(
  parameter int NUM_SLOTS   = tsw_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = tsw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tsw_item_if.sink                    in_ch,
  tsw_result_if.source                out_ch,
  input  logic                        cfg_wr_en,
  input  logic [tsw_pkg::BYTE_W-1:0]  cfg_wr_data
);

  // Command and status bundles between sequencer and datapath
  tsw_pkg::ctrl_cmd_t   cmd;
  tsw_pkg::ctrl_stat_t  stat;
  tsw_pkg::result_t     result;
  logic                 in_ready;
  logic                 out_valid;

  // Sequencer: owns the handshakes and the item phases
  tsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: slot memory, watchdog state, output register
  tsw_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_ch.data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (result)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = result;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tick scheduler with slave watchdog
// Runs directed cases (power-up state, tick byte, slot load and delete, run
// count saturation, lost slave) and several phases of random items. Each
// accepted item is predicted on a local copy of the slot table and compared
// field by field with the result item, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import tsw_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_LIMIT  = 40;
  localparam int SLOTS        = NUM_SLOTS_DEF;

  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [BYTE_W-1:0] cfg_wr_data;

  tsw_item_if   in_ch ();
  tsw_result_if out_ch ();

  tick_scheduler_with_slave_watchdog_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Local copy of the scheduler state, advanced once per accepted item
  logic               slot_live    [SLOTS];
  logic [FIELD_W-1:0] slot_left    [SLOTS];
  logic [FIELD_W-1:0] slot_repeat  [SLOTS];
  logic [BYTE_W-1:0]  slot_pending [SLOTS];
  logic               awaiting_first_tick;
  logic               last_wd_seen;
  logic               slave_lost;
  logic [BYTE_W-1:0]  tick_msg;

  // Results owed by the block, oldest first
  result_t sched_replies [$];

  int   mismatches = 0;
  int   cycle_cnt  = 0;
  int   burst_left = 0;
  int   rx_stall   = 0;
  int   rx_phase   = 0;
  logic wd_next    = 1'b1;   // watchdog level for the next good tick

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one item to the local state and return its result
  // --------------------------------------------------------------------------
  function automatic result_t sched_step(input item_t it);
    result_t           r;
    logic [MASK_W-1:0] due;
    r   = '0;
    due = '0;
    // A halted block answers everything with the lost flag alone
    if (slave_lost) begin
      r.lost_slave = 1'b1;
      return r;
    end
    case (it.func)
      FUNC_TICK: begin
        if (!awaiting_first_tick && (last_wd_seen == it.slave_watchdog)) begin
          // Watchdog did not toggle: halt for good, skip the walk
          slave_lost   = 1'b1;
          r.lost_slave = 1'b1;
        end else begin
          awaiting_first_tick = 1'b0;
          last_wd_seen        = it.slave_watchdog;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
              if (slot_left[i] == '0) begin
                if (slot_pending[i] != RUNS_MAX) slot_pending[i] = slot_pending[i] + 1'b1;
                if (i < MASK_W) due[i] = 1'b1;
                // One-shot slots keep a zero delay and stay due
                if (slot_repeat[i] != '0) slot_left[i] = slot_repeat[i];
              end else begin
                slot_left[i] = slot_left[i] - 1'b1;
              end
            end
          end
          r.tick_byte    = tick_msg;
          r.ack_captured = it.ack_byte;
          r.due_mask     = due;
        end
      end
      FUNC_WRITE: begin
        if (int'(it.slot_index) < SLOTS) begin
          slot_live[it.slot_index]    = it.slot_present;
          slot_left[it.slot_index]    = it.slot_present ? it.slot_delay : '0;
          slot_repeat[it.slot_index]  = it.slot_present ? it.slot_period : '0;
          slot_pending[it.slot_index] = '0;
        end
      end
      FUNC_DISPATCH: begin
        if (int'(it.slot_index) < SLOTS) begin
          r.run_count = slot_pending[it.slot_index];
          if (slot_pending[it.slot_index] != '0) begin
            slot_pending[it.slot_index] = slot_pending[it.slot_index] - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders: every field not used by the operation is random noise
  // --------------------------------------------------------------------------
  function automatic item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return item_t'(raw[$bits(item_t)-1:0]);
  endfunction

  // Good tick: flip the watchdog level relative to the last tick
  function automatic item_t tick_item(input logic [BYTE_W-1:0] ack);
    item_t it;
    it                = noise_item();
    it.func           = FUNC_TICK;
    it.slave_watchdog = wd_next;
    it.ack_byte       = ack;
    wd_next           = ~wd_next;
    return it;
  endfunction

  function automatic item_t write_item(input logic [IDX_W-1:0] idx, input logic present,
                                       input logic [FIELD_W-1:0] delay,
                                       input logic [FIELD_W-1:0] period);
    item_t it;
    it              = noise_item();
    it.func         = FUNC_WRITE;
    it.slot_index   = idx;
    it.slot_present = present;
    it.slot_delay   = delay;
    it.slot_period  = period;
    return it;
  endfunction

  function automatic item_t dispatch_item(input logic [IDX_W-1:0] idx);
    item_t it;
    it            = noise_item();
    it.func       = FUNC_DISPATCH;
    it.slot_index = idx;
    return it;
  endfunction

  function automatic item_t unused_item();
    item_t it;
    it      = noise_item();
    it.func = FUNC_UNUSED;
    return it;
  endfunction

  // Mostly short delays so slots fall due often; now and then any value
  function automatic logic [FIELD_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       pick_count = FIELD_W'($urandom);
      1, 2:    pick_count = FIELD_W'($urandom_range(0, 40));
      default: pick_count = FIELD_W'($urandom_range(0, 4));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Send one item in bursts of random length; between bursts drop valid for a
  // random gap, or roll straight into the next burst.
  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sched_replies.push_back(sched_step(it));
    burst_left--;
  endtask

  // Hold off the sender until every owed result has come, then let the
  // block settle.
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sched_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the tick message with the block idle
  task automatic write_tick_message(input logic [BYTE_W-1:0] value);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_msg = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: stall pattern and result check
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_LIMIT) begin
      $display("tb: mismatch in %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  task automatic check_reply(input result_t got);
    result_t want;
    if (sched_replies.size() == 0) begin
      report_mismatch("result with nothing owed", 64'(got), '0);
      return;
    end
    want = sched_replies.pop_front();
    if (got.lost_slave !== want.lost_slave) begin
      report_mismatch("lost_slave", 64'(got.lost_slave), 64'(want.lost_slave));
    end
    if (got.tick_byte !== want.tick_byte) begin
      report_mismatch("tick_byte", 64'(got.tick_byte), 64'(want.tick_byte));
    end
    if (got.ack_captured !== want.ack_captured) begin
      report_mismatch("ack_captured", 64'(got.ack_captured), 64'(want.ack_captured));
    end
    if (got.due_mask !== want.due_mask) begin
      report_mismatch("due_mask", 64'(got.due_mask), 64'(want.due_mask));
    end
    if (got.run_count !== want.run_count) begin
      report_mismatch("run_count", 64'(got.run_count), 64'(want.run_count));
    end
  endtask

  // Check each accepted result on the pre-edge values, then pick the next
  // ready level. The stall style follows bits 9:8 of a clock phase counter:
  // always ready, random, a fixed duty pattern, or rare long stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_stall = 0;
      rx_phase = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_reply(out_ch.data);
      rx_phase++;
      case (rx_phase[9:8])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= ($urandom_range(0, 2) != 0);
        2'd2: out_ch.ready <= (rx_phase[2:0] > 3'd2);
        default: begin
          if (rx_stall != 0) begin
            rx_stall--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(3, 14);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty slots, unused code, then the first tick (records the level only)
  // and a second good tick; ack extremes on both.
  task automatic test_power_up();
    send_item(dispatch_item(3'd0));
    send_item(dispatch_item(3'd7));
    send_item(unused_item());
    send_item(tick_item(8'h00));
    send_item(tick_item(8'hFF));
    send_item(unused_item());
  endtask

  // Tick byte follows each register write
  task automatic test_tick_message();
    write_tick_message(8'hFF);
    send_item(tick_item(8'h5A));
    send_item(tick_item(8'hA5));
    write_tick_message(8'h81);
    send_item(tick_item(8'h00));
  endtask

  // Load, reload, delete and dispatch slots, including the delay extremes,
  // a one-shot slot and dispatch of empty slots.
  task automatic test_slot_load();
    send_item(write_item(3'd0, 1'b1, 16'h0000, 16'h0000));
    send_item(write_item(3'd7, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(write_item(3'd3, 1'b1, 16'h0002, 16'h0001));
    send_item(write_item(3'd5, 1'b0, 16'hFFFF, 16'hFFFF));
    repeat (4) send_item(tick_item(8'($urandom)));
    send_item(dispatch_item(3'd0));
    send_item(dispatch_item(3'd3));
    send_item(dispatch_item(3'd5));
    send_item(dispatch_item(3'd7));
    send_item(dispatch_item(3'd3));
    // Rewrite clears the pending runs
    send_item(write_item(3'd3, 1'b1, 16'h0001, 16'h0000));
    send_item(dispatch_item(3'd3));
    repeat (2) send_item(tick_item(8'($urandom)));
    send_item(dispatch_item(3'd3));
    send_item(write_item(3'd0, 1'b0, 16'h1234, 16'h8001));
    send_item(dispatch_item(3'd0));
  endtask

  // A zero-delay one-shot slot is due on every tick; hold off dispatch until
  // its run count sits at the ceiling, then take two runs.
  task automatic test_run_saturation();
    send_item(write_item(3'd4, 1'b1, 16'h0000, 16'h0000));
    repeat (260) send_item(tick_item(8'($urandom)));
    send_item(dispatch_item(3'd4));
    send_item(dispatch_item(3'd4));
  endtask

  // Random phases, each under its own tick message. Ticks always toggle the
  // watchdog so the block stays alive; unused codes are the noise.
  task automatic test_random_traffic();
    logic [BYTE_W-1:0] msgs [4];
    int                pick;
    msgs = '{8'h00, 8'($urandom), 8'hFF, 8'($urandom)};
    foreach (msgs[p]) begin
      write_tick_message(msgs[p]);
      for (int n = 0; n < 212; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_item(tick_item(8'($urandom)));
        end else if (pick < 70) begin
          send_item(write_item(IDX_W'($urandom), ($urandom_range(0, 7) != 0),
                               pick_count(), pick_count()));
        end else if (pick < 95) begin
          send_item(dispatch_item(IDX_W'($urandom)));
        end else begin
          send_item(unused_item());
        end
      end
    end
  endtask

  // Repeat the last watchdog level: the block halts, and every later item,
  // good tick included, returns only the lost flag.
  task automatic test_lost_slave();
    item_t stuck;
    drain_replies();
    stuck                = noise_item();
    stuck.func           = FUNC_TICK;
    stuck.slave_watchdog = ~wd_next;
    send_item(stuck);
    send_item(tick_item(8'hFF));
    send_item(write_item(3'd2, 1'b1, 16'h0000, 16'h0001));
    send_item(dispatch_item(3'd4));
    send_item(unused_item());
    write_tick_message(8'h3C);
    send_item(tick_item(8'h11));
    send_item(tick_item(8'h22));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    foreach (slot_live[i]) begin
      slot_live[i]    = 1'b0;
      slot_left[i]    = '0;
      slot_repeat[i]  = '0;
      slot_pending[i] = '0;
    end
    awaiting_first_tick = 1'b1;
    last_wd_seen        = 1'b0;
    slave_lost          = 1'b0;
    tick_msg            = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_tick_message();
    test_slot_load();
    test_run_saturation();
    test_random_traffic();
    test_lost_slave();

    // Let every owed result arrive and watch for strays
    drain_replies();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tsw_pkg.sv
hw/rtl/tsw_item_if.sv
hw/rtl/tsw_result_if.sv
hw/rtl/tsw_dp.sv
hw/rtl/tsw_ctrl.sv
hw/rtl/tick_scheduler_with_slave_watchdog_top.sv
bench/tb.sv
